// ----- rtl/dfmi_pkg.sv -----
package dfmi_pkg;

    // Mode codes, shared by req_mode and mode
    localparam logic [2:0] MODE_GROUND    = 3'd0;
    localparam logic [2:0] MODE_FLIGHT    = 3'd1;
    localparam logic [2:0] MODE_TO_GROUND = 3'd2;
    localparam logic [2:0] MODE_TO_FLIGHT = 3'd3;
    localparam logic [2:0] MODE_FAULT     = 3'd4;

    // Rejection codes
    localparam logic [2:0] REJ_NONE      = 3'd0;
    localparam logic [2:0] REJ_NOTCFG    = 3'd1;
    localparam logic [2:0] REJ_TIMEOUT   = 3'd2;
    localparam logic [2:0] REJ_CHAIN     = 3'd3;
    localparam logic [2:0] REJ_ARMED     = 3'd4;
    localparam logic [2:0] REJ_NOTLANDED = 3'd5;
    localparam logic [2:0] REJ_MOVING    = 3'd6;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [1:0] REG_DELAY     = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    // Register reset values
    localparam logic [14:0] MAX_SPEED_RST = 15'd100;
    localparam logic [31:0] DELAY_RST     = 32'd1000000;
    localparam logic [31:0] TIMEOUT_RST   = 32'd10000000;

    // Widths of the stream words
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic [14:0] max_speed_cm_s;
        logic [31:0] delay_us;
        logic [31:0] timeout_us;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [63:0]        now_us;
        logic               enabled;
        logic [2:0]         req_mode;
        logic               armed;
        logic               landed;
        logic signed [15:0] speed_cm_s;
        logic               speed_valid;
        logic               ground_ready;
        logic               flight_ready;
    } item_t;

    typedef struct packed {
        logic       fault_cleared;
        logic       config_echo;
        logic       ground_active;
        logic       flight_active;
        logic       arm_lock;
        logic       mode_change_ok;
        logic [2:0] rejection;
        logic [2:0] mode;
    } result_t;

endpackage

// ----- rtl/dfmi_cfg.sv -----
module dfmi_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output dfmi_pkg::cfg_t      cfg
);

    logic [14:0] max_speed_reg;
    logic [31:0] delay_reg;
    logic [31:0] timeout_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= dfmi_pkg::MAX_SPEED_RST;
            delay_reg     <= dfmi_pkg::DELAY_RST;
            timeout_reg   <= dfmi_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                dfmi_pkg::REG_MAX_SPEED: max_speed_reg <= pwdata[14:0];
                dfmi_pkg::REG_DELAY:     delay_reg     <= pwdata;
                dfmi_pkg::REG_TIMEOUT:   timeout_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[3:2])
            dfmi_pkg::REG_MAX_SPEED: prdata = {17'd0, max_speed_reg};
            dfmi_pkg::REG_DELAY:     prdata = delay_reg;
            dfmi_pkg::REG_TIMEOUT:   prdata = timeout_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.max_speed_cm_s = max_speed_reg;
    assign cfg.delay_us       = delay_reg;
    assign cfg.timeout_us     = timeout_reg;

endmodule

// ----- rtl/dfmi_core.sv -----
module dfmi_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  dfmi_pkg::item_t      item,
    input  dfmi_pkg::cfg_t       cfg,
    output dfmi_pkg::result_t    result
);

    logic [2:0]  mode_reg,        mode_next;
    logic [63:0] tstart_reg,      tstart_next;
    logic        pend_active_reg, pend_active_next;
    logic [2:0]  pend_mode_reg,   pend_mode_next;
    logic [63:0] pend_since_reg,  pend_since_next;

    logic [64:0] tr_diff;
    logic [63:0] tr_el;
    logic [64:0] pd_diff;
    logic [63:0] pd_el;
    logic        tr_over, tr_done, tr_ready, in_transition;
    logic        pend_new, pend_go, req_ready, moving;
    logic [15:0] mag;
    logic        drop;
    logic [2:0]  rej;
    logic        allowed, cleared;

    // Elapsed times, floored at zero
    assign tr_diff = {1'b0, item.now_us} - {1'b0, tstart_reg};
    assign tr_el   = tr_diff[64] ? 64'd0 : tr_diff[63:0];
    assign pd_diff = {1'b0, item.now_us} - {1'b0, pend_since_reg};
    assign pd_el   = pd_diff[64] ? 64'd0 : pd_diff[63:0];

    assign in_transition = (mode_reg == dfmi_pkg::MODE_TO_GROUND) ||
                           (mode_reg == dfmi_pkg::MODE_TO_FLIGHT);
    assign tr_over  = tr_el > {32'd0, cfg.timeout_us};
    assign tr_done  = tr_el >= {32'd0, cfg.delay_us};
    assign tr_ready = (mode_reg == dfmi_pkg::MODE_TO_GROUND) ? item.ground_ready
                                                            : item.flight_ready;

    // Speed magnitude; most negative value gives 0x8000, always above limit
    assign mag    = item.speed_cm_s[15] ? (~item.speed_cm_s + 16'd1) : item.speed_cm_s;
    assign moving = !item.speed_valid || (mag > {1'b0, cfg.max_speed_cm_s});

    assign req_ready = (item.req_mode == dfmi_pkg::MODE_GROUND) ? item.ground_ready
                                                                : item.flight_ready;
    assign pend_new  = !pend_active_reg || (pend_mode_reg != item.req_mode);
    assign pend_go   = pend_new ? (cfg.delay_us == 32'd0)
                                : (pd_el >= {32'd0, cfg.delay_us});

    // One step of the interlock
    always_comb begin
        mode_next        = mode_reg;
        tstart_next      = tstart_reg;
        pend_active_next = pend_active_reg;
        pend_mode_next   = pend_mode_reg;
        pend_since_next  = pend_since_reg;
        drop             = 1'b0;
        rej              = dfmi_pkg::REJ_NONE;
        allowed          = 1'b0;
        cleared          = 1'b0;

        if (item.func) begin
            if (mode_reg == dfmi_pkg::MODE_FAULT && !item.armed && item.flight_ready) begin
                mode_next   = dfmi_pkg::MODE_FLIGHT;
                tstart_next = 64'd0;
                drop        = 1'b1;
                cleared     = 1'b1;
            end
        end else if (!item.enabled) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_NOTCFG;
        end else if (mode_reg == dfmi_pkg::MODE_FAULT) begin
            rej = dfmi_pkg::REJ_TIMEOUT;
        end else if (in_transition) begin
            if (tr_over) begin
                mode_next = dfmi_pkg::MODE_FAULT;
                rej       = dfmi_pkg::REJ_TIMEOUT;
            end else if (!tr_ready) begin
                rej = dfmi_pkg::REJ_CHAIN;
            end else begin
                allowed = 1'b1;
                if (tr_done) begin
                    mode_next = (mode_reg == dfmi_pkg::MODE_TO_GROUND) ?
                                dfmi_pkg::MODE_GROUND : dfmi_pkg::MODE_FLIGHT;
                end
            end
        end else if (item.req_mode == mode_reg) begin
            drop = 1'b1;
        end else if (item.req_mode != dfmi_pkg::MODE_FLIGHT &&
                     item.req_mode != dfmi_pkg::MODE_GROUND) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_CHAIN;
        end else if (item.armed) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_ARMED;
        end else if (!item.landed) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_NOTLANDED;
        end else if (moving) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_MOVING;
        end else if (!req_ready) begin
            drop = 1'b1;
            rej  = dfmi_pkg::REJ_CHAIN;
        end else begin
            allowed = 1'b1;
            if (pend_go) begin
                mode_next   = (item.req_mode == dfmi_pkg::MODE_GROUND) ?
                              dfmi_pkg::MODE_TO_GROUND : dfmi_pkg::MODE_TO_FLIGHT;
                tstart_next = item.now_us;
                drop        = 1'b1;
            end else if (pend_new) begin
                pend_active_next = 1'b1;
                pend_mode_next   = item.req_mode;
                pend_since_next  = item.now_us;
            end
        end

        // Dropping a request parks it on the mode left after this step
        if (drop) begin
            pend_active_next = 1'b0;
            pend_mode_next   = mode_next;
            pend_since_next  = 64'd0;
        end
    end

    // Result fields follow the mode after the step
    always_comb begin
        result.mode           = mode_next;
        result.rejection      = rej;
        result.mode_change_ok = allowed;
        result.arm_lock       = (mode_next == dfmi_pkg::MODE_TO_GROUND) ||
                                (mode_next == dfmi_pkg::MODE_TO_FLIGHT) ||
                                (mode_next == dfmi_pkg::MODE_FAULT);
        result.flight_active  = item.enabled && (mode_next == dfmi_pkg::MODE_FLIGHT);
        result.ground_active  = item.enabled && (mode_next == dfmi_pkg::MODE_GROUND);
        result.config_echo    = item.enabled;
        result.fault_cleared  = cleared;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= dfmi_pkg::MODE_FLIGHT;
            tstart_reg      <= 64'd0;
            pend_active_reg <= 1'b0;
            pend_mode_reg   <= dfmi_pkg::MODE_FLIGHT;
            pend_since_reg  <= 64'd0;
        end else if (step) begin
            mode_reg        <= mode_next;
            tstart_reg      <= tstart_next;
            pend_active_reg <= pend_active_next;
            pend_mode_reg   <= pend_mode_next;
            pend_since_reg  <= pend_since_next;
        end
    end

endmodule

// ----- rtl/drive_flight_mode_interlock.sv -----
// Flight mode interlock for a dual-mode vehicle.
//
// Input stream (s_*): one word per periodic status update or reset-fault
// command; s_tuser selects which. Result stream (m_*): exactly one result
// word per input word, in order.
// Configuration: APB-style registers max_speed_cm_s (0x0), delay_us (0x4),
// timeout_us (0x8); write only while the block is idle.
//
// An input register feeds the interlock logic, whose result lands in the output
// register at the same edge that updates the mode state. Throughput is one
// word per cycle while the receiver keeps m_tready high; the 64-bit
// elapsed-time subtract and compare sets the path.
//
// While the receiver stalls, the output register holds its word and the
// input register can still take one more word; then s_tready drops.
// Reset (aresetn low, synchronous) empties both registers, sets mode to
// flight, clears any pending request and restores register defaults.
module drive_flight_mode_interlock (
    input  logic                             aclk,
    input  logic                             aresetn,
    // in: func
    input  logic                             s_tuser,
    // in: now_us[63:0], enabled[64], req_mode[67:65], armed[68],
    //     landed[69], speed_cm_s[85:70], speed_valid[86], ground_ready[87],
    //     flight_ready[88], zero pad[95:89]
    input  logic [dfmi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // out: mode[2:0], rejection[5:3], mode_change_ok[6], arm_lock[7],
    //      flight_active[8], ground_active[9], config_echo[10],
    //      fault_cleared[11], zero pad[15:12]
    output logic [dfmi_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    dfmi_pkg::cfg_t    cfg;
    dfmi_pkg::item_t   item_reg;
    dfmi_pkg::result_t result;
    dfmi_pkg::result_t res_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              step;
    logic              s_take;

    dfmi_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline control: process when the output slot is free or draining
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input register: unpack the word
    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_reg.func         <= s_tuser;
            item_reg.now_us       <= s_tdata[63:0];
            item_reg.enabled      <= s_tdata[64];
            item_reg.req_mode     <= s_tdata[67:65];
            item_reg.armed        <= s_tdata[68];
            item_reg.landed       <= s_tdata[69];
            item_reg.speed_cm_s   <= s_tdata[85:70];
            item_reg.speed_valid  <= s_tdata[86];
            item_reg.ground_ready <= s_tdata[87];
            item_reg.flight_ready <= s_tdata[88];
        end
    end

    dfmi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg};

    // A cleared fault always lands in flight mode
    a_clear_to_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.fault_cleared |-> res_reg.mode == dfmi_pkg::MODE_FLIGHT)
        else $error("fault cleared but mode is not flight");

    // A timeout rejection always reports the fault mode
    a_timeout_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.rejection == dfmi_pkg::REJ_TIMEOUT
        |-> res_reg.mode == dfmi_pkg::MODE_FAULT)
        else $error("timeout rejection without fault mode");

    // An allowed transition carries no rejection
    a_allowed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.mode_change_ok |-> res_reg.rejection == dfmi_pkg::REJ_NONE)
        else $error("transition allowed with rejection");

    // A processed word always reaches the output register on the next edge
    a_step_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("processed word lost");

endmodule
